// ===== rtl/csl_pkg.sv =====
`default_nettype none
package csl_pkg;

    typedef enum logic [2:0] {
        SQ_IN, SQ_A, SQ_A2, SQ_DRD, SQ_DEM, SQ_B, SQ_C, SQ_FIN
    } seq_t;

    typedef enum logic [2:0] {
        SC_IDLE, SC_IDENT, SC_NUMBER, SC_STRING, SC_CHAR_OPEN, SC_CHAR_HAVE, SC_OP
    } scan_t;

    typedef enum logic [1:0] {
        RET_B, RET_C, RET_FIN
    } ret_t;

    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_INT     = 6'd1;
    localparam logic [5:0] K_CHAR    = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_KEY0    = 6'd4;
    localparam logic [5:0] K_PLUS    = 6'd17;
    localparam logic [5:0] K_MINUS   = 6'd18;
    localparam logic [5:0] K_TIMES   = 6'd19;
    localparam logic [5:0] K_SLASH   = 6'd20;
    localparam logic [5:0] K_LSS     = 6'd21;
    localparam logic [5:0] K_LEQ     = 6'd22;
    localparam logic [5:0] K_GRE     = 6'd23;
    localparam logic [5:0] K_GEQ     = 6'd24;
    localparam logic [5:0] K_EQL     = 6'd25;
    localparam logic [5:0] K_NEQ     = 6'd26;
    localparam logic [5:0] K_ASSIGN  = 6'd27;
    localparam logic [5:0] K_SEMI    = 6'd28;
    localparam logic [5:0] K_COMMA   = 6'd29;
    localparam logic [5:0] K_LPAREN  = 6'd30;
    localparam logic [5:0] K_RPAREN  = 6'd31;
    localparam logic [5:0] K_LBRACK  = 6'd32;
    localparam logic [5:0] K_RBRACK  = 6'd33;
    localparam logic [5:0] K_LBRACE  = 6'd34;
    localparam logic [5:0] K_RBRACE  = 6'd35;
    localparam logic [5:0] K_NEWLINE = 6'd36;
    localparam logic [5:0] K_ERROR   = 6'd37;

    localparam int NUM_KW = 13;

    localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
        '{"c", "o", "n", "s", "t", 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"s", "c", "a", "n", "f", 8'h00},
        '{"p", "r", "i", "n", "t", "f"},
        '{"r", "e", "t", "u", "r", "n"}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic        has;
        logic        tend;
        logic [15:0] line;
        logic        tl;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
    endfunction

    // single-character operators; top bit says whether it is one
    function automatic logic [6:0] op_kind(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c)
            "+":     r = {1'b1, K_PLUS};
            "-":     r = {1'b1, K_MINUS};
            "*":     r = {1'b1, K_TIMES};
            "/":     r = {1'b1, K_SLASH};
            ";":     r = {1'b1, K_SEMI};
            ",":     r = {1'b1, K_COMMA};
            "(":     r = {1'b1, K_LPAREN};
            ")":     r = {1'b1, K_RPAREN};
            "[":     r = {1'b1, K_LBRACK};
            "]":     r = {1'b1, K_RBRACK};
            "{":     r = {1'b1, K_LBRACE};
            "}":     r = {1'b1, K_RBRACE};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/csl_in_if.sv =====
`default_nettype none
interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== rtl/csl_out_if.sv =====
`default_nettype none
interface csl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [7:0]  text_char;
    logic        has_text;
    logic        token_end;
    logic [15:0] line_number;
    logic        too_long;
    logic        run_last;

    modport source (output valid, output token_kind, output text_char, output has_text,
                    output token_end, output line_number, output too_long,
                    output run_last, input ready);
    modport sink (input valid, input token_kind, input text_char, input has_text,
                  input token_end, input line_number, input too_long,
                  input run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/csl_ram.sv =====
`default_nettype none
module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/c_subset_lexer.sv =====
`default_nettype none
// Streaming lexer for a small C subset. One source byte is taken per beat on
// text; every token leaves on tokens as a run of beats, one per character or
// a single beat with no character, with token_end on the last one and run_last
// on the last beat caused by an input byte. Identifier, number and string
// text is held in a MAX_TOKEN_LEN byte RAM and read back one character at a
// time, each read first waiting for the registered RAM data. The next byte
// is taken only once all beats of the previous one have been handed to the
// output register.
module c_subset_lexer #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    csl_in_if.sink    text,
    csl_out_if.source tokens
);
    import csl_pkg::*;

    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);

    seq_t               seq_reg, seq_next, seq_tgt;
    scan_t              scan_reg, scan_next;
    ret_t               ret_reg, ret_next;
    logic [LEN_W-1:0]   len_reg, len_next, idx_reg, idx_next;
    logic               ovf_reg, ovf_next;
    logic [15:0]        line_reg, line_next;
    logic [7:0]         held_reg, held_next;
    logic [NUM_KW-1:0]  mask_reg, mask_next;
    logic [7:0]         c_reg;
    logic               eot_reg;
    logic [5:0]         dkind_reg, dkind_next;
    res_t               pend_reg, pend_next;
    logic               pend_v_reg, pend_v_next;
    res_t               out_reg;
    logic               out_last_reg, out_v_reg;

    logic               can_push, emit_ok, emit_req, fire, push, push_last, done;
    res_t               emit_res;
    logic               do_app;
    logic [LEN_W-1:0]   app_base;
    logic [NUM_KW-1:0]  mask_base;
    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [7:0]         rdata;
    logic [5:0]         id_kind, held_dbl;
    res_t               held_one;
    logic [6:0]         opk;

    csl_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN_LEN)) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (c_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign text.ready = (seq_reg == SQ_IN);
    assign can_push   = !out_v_reg || tokens.ready;
    assign emit_ok    = !pend_v_reg || can_push;
    assign fire       = emit_req && emit_ok;

    assign tokens.valid       = out_v_reg;
    assign tokens.token_kind  = out_reg.kind;
    assign tokens.text_char   = out_reg.ch;
    assign tokens.has_text    = out_reg.has;
    assign tokens.token_end   = out_reg.tend;
    assign tokens.line_number = out_reg.line;
    assign tokens.too_long    = out_reg.tl;
    assign tokens.run_last    = out_last_reg;

    assign opk = op_kind(c_reg);

    // keyword lookup from the running prefix match
    always_comb
    begin
        id_kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (mask_reg[k] && !ovf_reg && (LEN_W'(KW_LEN[k]) == len_reg))
            begin
                id_kind = K_KEY0 + 6'(k);
            end
        end
    end

    always_comb
    begin
        held_one = '{kind: K_ERROR, ch: 8'h00, has: 1'b0, tend: 1'b1,
                     line: line_reg, tl: 1'b0};
        held_dbl = K_NEQ;
        case (held_reg)
            ">":
            begin
                held_one = '{kind: K_GRE, ch: held_reg, has: 1'b1, tend: 1'b1,
                             line: line_reg, tl: 1'b0};
                held_dbl = K_GEQ;
            end
            "<":
            begin
                held_one = '{kind: K_LSS, ch: held_reg, has: 1'b1, tend: 1'b1,
                             line: line_reg, tl: 1'b0};
                held_dbl = K_LEQ;
            end
            "=":
            begin
                held_one = '{kind: K_ASSIGN, ch: held_reg, has: 1'b1, tend: 1'b1,
                             line: line_reg, tl: 1'b0};
                held_dbl = K_EQL;
            end
            default:
            begin
                held_dbl = K_NEQ;
            end
        endcase
    end

    // actions of each sequencer step
    always_comb
    begin
        scan_next = scan_reg;
        ret_next  = ret_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        held_next = held_reg;
        mask_next = mask_reg;
        dkind_next = dkind_reg;
        emit_req  = 1'b0;
        emit_res  = '{kind: K_ERROR, ch: 8'h00, has: 1'b0, tend: 1'b1,
                      line: line_reg, tl: 1'b0};
        done      = 1'b1;
        seq_tgt   = seq_reg;
        push_last = 1'b0;
        do_app    = 1'b0;
        app_base  = len_reg;
        mask_base = mask_reg;
        re        = 1'b0;
        raddr     = idx_reg[ADDR_W-1:0];
        we        = 1'b0;
        waddr     = len_reg[ADDR_W-1:0];

        case (seq_reg)
            SQ_IN:
            begin
                done    = text.valid;
                seq_tgt = SQ_A;
            end
            SQ_A:
            begin
                seq_tgt = SQ_B;
                case (scan_reg)
                    SC_NUMBER:
                    begin
                        if (is_digit(c_reg))
                        begin
                            do_app  = 1'b1;
                            seq_tgt = SQ_C;
                        end
                        else
                        begin
                            dkind_next = K_INT;
                            ret_next   = RET_B;
                            idx_next   = '0;
                            seq_tgt    = SQ_DRD;
                        end
                    end
                    SC_IDENT:
                    begin
                        if (is_digit(c_reg) || is_alpha(c_reg))
                        begin
                            do_app  = 1'b1;
                            seq_tgt = SQ_C;
                        end
                        else
                        begin
                            dkind_next = id_kind;
                            ret_next   = RET_B;
                            idx_next   = '0;
                            seq_tgt    = SQ_DRD;
                        end
                    end
                    SC_STRING:
                    begin
                        if (c_reg == 8'h0a)
                        begin
                            emit_req = 1'b1;
                            done     = emit_ok;
                        end
                        else if (c_reg == "\"")
                        begin
                            scan_next  = SC_IDLE;
                            dkind_next = K_STRING;
                            ret_next   = RET_C;
                            idx_next   = '0;
                            seq_tgt    = SQ_DRD;
                        end
                        else
                        begin
                            do_app  = 1'b1;
                            seq_tgt = SQ_C;
                        end
                    end
                    SC_CHAR_OPEN:
                    begin
                        held_next = c_reg;
                        scan_next = SC_CHAR_HAVE;
                        seq_tgt   = SQ_C;
                    end
                    SC_CHAR_HAVE:
                    begin
                        emit_req = 1'b1;
                        done     = emit_ok;
                        if (c_reg == "'")
                        begin
                            emit_res = '{kind: K_CHAR, ch: held_reg, has: 1'b1,
                                         tend: 1'b1, line: line_reg, tl: 1'b0};
                            scan_next = SC_IDLE;
                            seq_tgt   = SQ_C;
                        end
                    end
                    SC_OP:
                    begin
                        emit_req = 1'b1;
                        done     = emit_ok;
                        if (c_reg == "=")
                        begin
                            emit_res = '{kind: held_dbl, ch: held_reg, has: 1'b1,
                                         tend: 1'b0, line: line_reg, tl: 1'b0};
                            seq_tgt  = SQ_A2;
                        end
                        else
                        begin
                            emit_res = held_one;
                        end
                    end
                    default:
                    begin
                        seq_tgt = SQ_B;
                    end
                endcase
            end
            SQ_A2:
            begin
                emit_req  = 1'b1;
                done      = emit_ok;
                emit_res  = '{kind: held_dbl, ch: "=", has: 1'b1, tend: 1'b1,
                              line: line_reg, tl: 1'b0};
                scan_next = SC_IDLE;
                seq_tgt   = SQ_C;
            end
            SQ_DRD:
            begin
                if (len_reg == '0)
                begin
                    // empty token text: a single beat with no character
                    emit_req = 1'b1;
                    done     = emit_ok;
                    emit_res = '{kind: dkind_reg, ch: 8'h00, has: 1'b0, tend: 1'b1,
                                 line: line_reg, tl: ovf_reg};
                    ovf_next = 1'b0;
                    case (ret_reg)
                        RET_B:   seq_tgt = SQ_B;
                        RET_C:   seq_tgt = SQ_C;
                        default: seq_tgt = SQ_FIN;
                    endcase
                end
                else
                begin
                    re      = 1'b1;
                    seq_tgt = SQ_DEM;
                end
            end
            SQ_DEM:
            begin
                emit_req = 1'b1;
                done     = emit_ok;
                emit_res = '{kind: dkind_reg, ch: rdata, has: 1'b1,
                             tend: (idx_reg + 1'b1 == len_reg),
                             line: line_reg, tl: ovf_reg};
                if (idx_reg + 1'b1 == len_reg)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    case (ret_reg)
                        RET_B:   seq_tgt = SQ_B;
                        RET_C:   seq_tgt = SQ_C;
                        default: seq_tgt = SQ_FIN;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    seq_tgt  = SQ_DRD;
                end
            end
            SQ_B:
            begin
                seq_tgt   = SQ_C;
                scan_next = SC_IDLE;
                len_next  = '0;
                ovf_next  = 1'b0;
                app_base  = '0;
                mask_base = '1;
                mask_next = '1;
                if (c_reg == 8'h0a)
                begin
                    emit_req = 1'b1;
                    done     = emit_ok;
                    emit_res = '{kind: K_NEWLINE, ch: 8'h00, has: 1'b0, tend: 1'b1,
                                 line: line_reg, tl: 1'b0};
                    if (line_reg != 16'hffff)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                end
                else if (is_space(c_reg))
                begin
                    scan_next = SC_IDLE;
                end
                else if (is_digit(c_reg))
                begin
                    scan_next = SC_NUMBER;
                    do_app    = 1'b1;
                end
                else if (is_alpha(c_reg))
                begin
                    scan_next = SC_IDENT;
                    do_app    = 1'b1;
                end
                else if (c_reg == "\"")
                begin
                    scan_next = SC_STRING;
                end
                else if (c_reg == "'")
                begin
                    scan_next = SC_CHAR_OPEN;
                end
                else if ((c_reg == ">") || (c_reg == "<") || (c_reg == "=") || (c_reg == "!"))
                begin
                    scan_next = SC_OP;
                    held_next = c_reg;
                end
                else
                begin
                    emit_req = 1'b1;
                    done     = emit_ok;
                    if (opk[6])
                    begin
                        emit_res = '{kind: opk[5:0], ch: c_reg, has: 1'b1, tend: 1'b1,
                                     line: line_reg, tl: 1'b0};
                    end
                end
            end
            SQ_C:
            begin
                seq_tgt = SQ_FIN;
                if (eot_reg)
                begin
                    scan_next = SC_IDLE;
                    case (scan_reg)
                        SC_NUMBER, SC_IDENT:
                        begin
                            dkind_next = (scan_reg == SC_IDENT) ? id_kind : K_INT;
                            ret_next   = RET_FIN;
                            idx_next   = '0;
                            seq_tgt    = SQ_DRD;
                        end
                        SC_OP:
                        begin
                            emit_req = 1'b1;
                            done     = emit_ok;
                            emit_res = held_one;
                        end
                        SC_STRING, SC_CHAR_OPEN, SC_CHAR_HAVE:
                        begin
                            emit_req = 1'b1;
                            done     = emit_ok;
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                        default:
                        begin
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                    endcase
                end
            end
            SQ_FIN:
            begin
                seq_tgt   = SQ_IN;
                push_last = pend_v_reg;
                done      = !pend_v_reg || can_push;
            end
            default:
            begin
                seq_tgt = SQ_IN;
            end
        endcase

        // append the current byte to the token buffer
        if (do_app)
        begin
            if (app_base < LEN_W'(MAX_TOKEN_LEN))
            begin
                we       = 1'b1;
                waddr    = app_base[ADDR_W-1:0];
                len_next = app_base + 1'b1;
                for (int k = 0; k < NUM_KW; k++)
                begin
                    mask_next[k] = mask_base[k] && (app_base < LEN_W'(KW_LEN[k])) &&
                                   (KW_TEXT[k][app_base[2:0]] == c_reg);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        seq_next = done ? seq_tgt : seq_reg;
    end

    // one-beat holding stage so the last beat of a byte can be marked
    always_comb
    begin
        push        = (fire && pend_v_reg) || (push_last && can_push);
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        if (fire)
        begin
            pend_next   = emit_res;
            pend_v_next = 1'b1;
        end
        else if (push_last && can_push)
        begin
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SQ_IN;
            scan_reg   <= SC_IDLE;
            ret_reg    <= RET_B;
            len_reg    <= '0;
            idx_reg    <= '0;
            ovf_reg    <= 1'b0;
            line_reg   <= 16'd1;
            held_reg   <= 8'h00;
            mask_reg   <= '1;
            dkind_reg  <= K_IDENT;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            pend_v_reg <= pend_v_next;
            if (done)
            begin
                scan_reg  <= scan_next;
                ret_reg   <= ret_next;
                len_reg   <= len_next;
                idx_reg   <= idx_next;
                ovf_reg   <= ovf_next;
                line_reg  <= line_next;
                held_reg  <= held_next;
                mask_reg  <= mask_next;
                dkind_reg <= dkind_next;
            end
            if (push)
            begin
                out_v_reg <= 1'b1;
            end
            else if (tokens.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            c_reg   <= text.char_in;
            eot_reg <= text.end_of_text;
        end
        pend_reg <= pend_next;
        if (push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_c_subset_lexer.sv =====
`timescale 1ns / 1ps
module tb_c_subset_lexer;
    import csl_pkg::*;

    localparam int TOKEN_CAP   = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } src_byte_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic        has;
        logic        tend;
        logic [15:0] line;
        logic        tl;
        logic        last;
    } token_beat_t;

    logic clk;
    logic rst_n;

    csl_in_if  text();
    csl_out_if tokens();

    c_subset_lexer #(.MAX_TOKEN_LEN(TOKEN_CAP)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text.sink),
        .tokens (tokens.source)
    );

    // predictor state
    scan_t       lx_state;
    logic [7:0]  lx_buf [TOKEN_CAP];
    int          lx_len;
    logic [15:0] lx_line;
    logic        lx_ovf;
    logic [7:0]  lx_held;

    src_byte_t   pending_bytes [$];
    token_beat_t expected_beats [$];
    token_beat_t step_beats [$];

    int  error_count;
    int  cycle_count;
    logic stimulus_done;

    function automatic logic lx_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic lx_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    task automatic push_beat(input logic [5:0] kind, input logic [7:0] ch, input logic has,
                             input logic tend, input logic tl);
        token_beat_t b;
        b.kind = kind;
        b.ch   = has ? ch : 8'h00;
        b.has  = has;
        b.tend = tend;
        b.line = lx_line;
        b.tl   = tl;
        b.last = 1'b0;
        step_beats = {step_beats, b};
    endtask

    task automatic append_char(input logic [7:0] c);
        if (lx_len < TOKEN_CAP)
        begin
            lx_buf[lx_len] = c;
            lx_len++;
        end
        else
            lx_ovf = 1'b1;
    endtask

    task automatic flush_text(input logic [5:0] kind);
        if (lx_len == 0)
            push_beat(kind, 8'h00, 1'b0, 1'b1, lx_ovf);
        else
            for (int i = 0; i < lx_len; i++)
                push_beat(kind, lx_buf[i], 1'b1, i + 1 == lx_len, lx_ovf);
        lx_len = 0;
        lx_ovf = 1'b0;
    endtask

    task automatic flush_word();
        string kws [13];
        logic [5:0] kind;
        logic hit;
        kws = '{"const", "int", "char", "void", "main", "if", "else", "do", "while",
                "for", "scanf", "printf", "return"};
        kind = K_IDENT;
        if (!lx_ovf)
            for (int k = 0; k < 13; k++)
            begin
                hit = kws[k].len() == lx_len;
                for (int j = 0; j < lx_len && hit; j++)
                    if (kws[k][j] != lx_buf[j])
                        hit = 1'b0;
                if (hit)
                    kind = K_KEY0 + 6'(k);
            end
        flush_text(kind);
    endtask

    task automatic held_single();
        case (lx_held)
            8'h3e: push_beat(K_GRE, 8'h3e, 1'b1, 1'b1, 1'b0);
            8'h3c: push_beat(K_LSS, 8'h3c, 1'b1, 1'b1, 1'b0);
            8'h3d: push_beat(K_ASSIGN, 8'h3d, 1'b1, 1'b1, 1'b0);
            default: push_beat(K_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
        endcase
    endtask

    task automatic held_double();
        logic [5:0] kind;
        case (lx_held)
            8'h3e: kind = K_GEQ;
            8'h3c: kind = K_LEQ;
            8'h3d: kind = K_EQL;
            default: kind = K_NEQ;
        endcase
        push_beat(kind, lx_held, 1'b1, 1'b0, 1'b0);
        push_beat(kind, 8'h3d, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic begin_token(input logic [7:0] c);
        logic [6:0] op;
        lx_state = SC_IDLE;
        lx_len = 0;
        lx_ovf = 1'b0;
        case (c)
            8'h0a:
            begin
                push_beat(K_NEWLINE, 8'h00, 1'b0, 1'b1, 1'b0);
                if (lx_line != 16'hffff)
                    lx_line++;
            end
            8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: ;
            8'h22: lx_state = SC_STRING;
            8'h27: lx_state = SC_CHAR_OPEN;
            8'h3e, 8'h3c, 8'h3d, 8'h21:
            begin
                lx_state = SC_OP;
                lx_held = c;
            end
            default:
            begin
                if (lx_digit(c))
                begin
                    lx_state = SC_NUMBER;
                    append_char(c);
                end
                else if (lx_alpha(c))
                begin
                    lx_state = SC_IDENT;
                    append_char(c);
                end
                else
                begin
                    case (c)
                        8'h2b: op = {1'b1, K_PLUS};
                        8'h2d: op = {1'b1, K_MINUS};
                        8'h2a: op = {1'b1, K_TIMES};
                        8'h2f: op = {1'b1, K_SLASH};
                        8'h3b: op = {1'b1, K_SEMI};
                        8'h2c: op = {1'b1, K_COMMA};
                        8'h28: op = {1'b1, K_LPAREN};
                        8'h29: op = {1'b1, K_RPAREN};
                        8'h5b: op = {1'b1, K_LBRACK};
                        8'h5d: op = {1'b1, K_RBRACK};
                        8'h7b: op = {1'b1, K_LBRACE};
                        8'h7d: op = {1'b1, K_RBRACE};
                        default: op = 7'd0;
                    endcase
                    if (op[6])
                        push_beat(op[5:0], c, 1'b1, 1'b1, 1'b0);
                    else
                        push_beat(K_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                end
            end
        endcase
    endtask

    task automatic lex_byte(input src_byte_t sb);
        logic [7:0] c;
        c = sb.ch;
        step_beats.delete();
        case (lx_state)
            SC_NUMBER:
                if (lx_digit(c))
                    append_char(c);
                else
                begin
                    flush_text(K_INT);
                    begin_token(c);
                end
            SC_IDENT:
                if (lx_alpha(c) || lx_digit(c))
                    append_char(c);
                else
                begin
                    flush_word();
                    begin_token(c);
                end
            SC_STRING:
                if (c == 8'h0a)
                begin
                    push_beat(K_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                    begin_token(c);
                end
                else if (c == 8'h22)
                begin
                    flush_text(K_STRING);
                    lx_state = SC_IDLE;
                end
                else
                    append_char(c);
            SC_CHAR_OPEN:
            begin
                lx_held = c;
                lx_state = SC_CHAR_HAVE;
            end
            SC_CHAR_HAVE:
                if (c == 8'h27)
                begin
                    push_beat(K_CHAR, lx_held, 1'b1, 1'b1, 1'b0);
                    lx_state = SC_IDLE;
                end
                else
                begin
                    push_beat(K_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                    begin_token(c);
                end
            SC_OP:
                if (c == 8'h3d)
                begin
                    held_double();
                    lx_state = SC_IDLE;
                end
                else
                begin
                    held_single();
                    begin_token(c);
                end
            default: begin_token(c);
        endcase
        if (sb.eot)
        begin
            case (lx_state)
                SC_NUMBER: flush_text(K_INT);
                SC_IDENT: flush_word();
                SC_OP: held_single();
                SC_STRING, SC_CHAR_OPEN, SC_CHAR_HAVE:
                    push_beat(K_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                default: ;
            endcase
            lx_state = SC_IDLE;
            lx_len = 0;
            lx_ovf = 1'b0;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            expected_beats = {expected_beats, step_beats[i]};
    endtask

    task automatic queue_text(input string s, input logic eot_at_end);
        src_byte_t sb;
        for (int i = 0; i < s.len(); i++)
        begin
            sb.ch  = s[i];
            sb.eot = eot_at_end && (i == s.len() - 1);
            pending_bytes = {pending_bytes, sb};
        end
    endtask

    function automatic logic [7:0] random_byte();
        string alphabet;
        alphabet = "abcxyz_AZ09 \t\n\"'+-*/;,()[]{}<>=!";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
        endcase
    endfunction

    function automatic string random_lexeme();
        string words [10];
        string s;
        int n;
        words = '{"const", "int", "char", "void", "main", "if", "else", "while",
                  "for", "return"};
        s = "";
        case ($urandom_range(0, 7))
            0: s = words[$urandom_range(0, 9)];
            1: s = {"scanf", " "};
            2:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(8'h30, 8'h39)))};
            end
            3:
            begin
                n = $urandom_range(0, 5);
                s = "\"";
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(8'h61, 8'h7a)))};
                s = {s, "\""};
            end
            4: s = {"'", string'(8'($urandom_range(8'h20, 8'h7e))), "'"};
            5: s = $urandom_range(0, 1) ? "<=" : ">=";
            6: s = $urandom_range(0, 1) ? "printf" : "!=";
            default: s = {"v", string'(8'($urandom_range(8'h61, 8'h7a)))};
        endcase
        return {s, string'(8'h20)};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        string s;
        src_byte_t sb;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        // directed text: keywords split by operators, held operators, edge bytes
        queue_text("const(int)char;void,main+if-else*do/while[for]scanf{printf}return\n", 0);
        queue_text("<<=>>===!=!x", 0);
        queue_text("\t\v\f\r 09 \"ab\" \"\" 'q' 'ab \"c\n", 0);
        s = "";
        for (int i = 0; i < 33; i++)
            s = {s, "k"};
        queue_text({s, " "}, 0);
        sb.ch = 8'hff; sb.eot = 1'b0; pending_bytes = {pending_bytes, sb};
        sb.ch = 8'h80; sb.eot = 1'b0; pending_bytes = {pending_bytes, sb};
        sb.ch = 8'h00; sb.eot = 1'b0; pending_bytes = {pending_bytes, sb};
        queue_text("ab", 1);
        queue_text("\"o", 1);
        queue_text("'", 1);
        queue_text("<", 1);
        queue_text("42", 1);
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                sb.ch  = random_byte();
                sb.eot = ($urandom_range(0, 15) == 0);
                pending_bytes = {pending_bytes, sb};
            end
            else
                queue_text(random_lexeme(), $urandom_range(0, 20) == 0);
        end
        queue_text("\n", 1);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        stimulus_done = 1'b1;
    end

    // text driver: bursts and gaps
    int burst_left;
    int gap_left;
    logic text_taken;
    always @(posedge clk)
        text_taken <= rst_n && text.valid && text.ready;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            text.valid       <= 1'b0;
            text.char_in     <= 8'h00;
            text.end_of_text <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!text.valid || text_taken)
        begin
            if (text_taken && pending_bytes.size() > 0)
                void'(pending_bytes.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                text.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    text.valid <= 1'b0;
                end
                else
                begin
                    burst_left--;
                    text.valid       <= 1'b1;
                    text.char_in     <= pending_bytes[0].ch;
                    text.end_of_text <= pending_bytes[0].eot;
                end
            end
            else
                text.valid <= 1'b0;
        end
    end

    // prediction on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_state = SC_IDLE;
            lx_len = 0;
            lx_line = 16'd1;
            lx_ovf = 1'b0;
            lx_held = 8'h00;
        end
        else if (text.valid && text.ready)
        begin
            src_byte_t sb;
            sb.ch  = text.char_in;
            sb.eot = text.end_of_text;
            lex_byte(sb);
        end
    end

    // receiver stalls, with one long hold-off early on
    int hold_cycles;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            tokens.ready <= 1'b0;
            hold_cycles = 0;
        end
        else if (cycle_count == 300)
        begin
            hold_cycles = 400;
            tokens.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            tokens.ready <= 1'b0;
        end
        else
            tokens.ready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // token monitor
    always @(posedge clk)
    begin
        token_beat_t exp_b;
        if (rst_n && tokens.valid && tokens.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("token beat with nothing expected: kind %0d", tokens.token_kind);
                error_count++;
            end
            else
            begin
                exp_b = expected_beats.pop_front();
                if (tokens.token_kind !== exp_b.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", exp_b.kind, tokens.token_kind);
                    error_count++;
                end
                if (tokens.text_char !== exp_b.ch)
                begin
                    $error("text_char: expected %0h, got %0h", exp_b.ch, tokens.text_char);
                    error_count++;
                end
                if (tokens.has_text !== exp_b.has)
                begin
                    $error("has_text: expected %0b, got %0b", exp_b.has, tokens.has_text);
                    error_count++;
                end
                if (tokens.token_end !== exp_b.tend)
                begin
                    $error("token_end: expected %0b, got %0b", exp_b.tend, tokens.token_end);
                    error_count++;
                end
                if (tokens.line_number !== exp_b.line)
                begin
                    $error("line_number: expected %0d, got %0d", exp_b.line,
                           tokens.line_number);
                    error_count++;
                end
                if (tokens.too_long !== exp_b.tl)
                begin
                    $error("too_long: expected %0b, got %0b", exp_b.tl, tokens.too_long);
                    error_count++;
                end
                if (tokens.run_last !== exp_b.last)
                begin
                    $error("run_last: expected %0b, got %0b", exp_b.last, tokens.run_last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        fork
            begin
                forever
                begin
                    @(posedge clk);
                    cycle_count++;
                end
            end
            begin
                @(posedge stimulus_done);
                wait (pending_bytes.size() == 0 && !text.valid && expected_beats.size() == 0);
                repeat (200) @(posedge clk);
                if (error_count == 0 && expected_beats.size() == 0)
                    $display("Testbench completed without errors");
                else
                    $display("Testbench completed WITH ERRORS");
                $finish;
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        join
    end

endmodule

// ===== c_subset_lexer.f =====
rtl/csl_pkg.sv
rtl/csl_in_if.sv
rtl/csl_out_if.sv
rtl/csl_ram.sv
rtl/c_subset_lexer.sv
sim/tb_c_subset_lexer.sv
